/* rtl/tts_pkg.sv */
`default_nettype none
package tts_pkg;

  localparam int SLIP_FRAC_BITS = 12;

  localparam int NUM_W = 44;
  localparam int DEN_W = 27;
  localparam int CNT_W = $clog2(NUM_W + 1);

  localparam logic [1:0] CMD_FRAME = 2'd0;
  localparam logic [1:0] CMD_TICK  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [2:0] REG_PEDAL_ID   = 3'd0;
  localparam logic [2:0] REG_WHEEL_ID   = 3'd1;
  localparam logic [2:0] REG_THRESHOLD  = 3'd2;
  localparam logic [2:0] REG_PEDAL_TMO  = 3'd3;
  localparam logic [2:0] REG_WHEEL_TMO  = 3'd4;
  localparam logic [2:0] REG_MAX_TORQUE = 3'd5;
  localparam logic [2:0] REG_DERATE_BEG = 3'd6;
  localparam logic [2:0] REG_DERATE_CUT = 3'd7;

  localparam logic [9:0]  BRAKE_OVERRIDE = 10'd20;
  localparam logic [16:0] REF_FLOOR_SUM  = 17'd1000;
  localparam logic [9:0]  PEDAL_FULL     = 10'd1000;

  typedef enum logic [1:0] {
    DS_READY  = 2'd0,
    DS_DERATE = 2'd1,
    DS_FAULT  = 2'd2
  } drive_state_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SLIP,
    S_SLIP_WAIT,
    S_SLIP_SAT,
    S_DECIDE,
    S_MUL,
    S_TQ_START,
    S_TQ_WAIT,
    S_EMIT
  } sup_state_t;

endpackage
`default_nettype wire

/* rtl/tts_serial_div.sv */
`default_nettype none
module tts_serial_div import tts_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic [NUM_W-1:0]      quo
);

  logic [NUM_W-1:0] shift;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   diff;
  logic             ge;
  logic [DEN_W-1:0] rem_next;

  always_comb begin
    rem_sh   = {rem, shift[NUM_W-1]};
    diff     = rem_sh - {1'b0, den_r};
    ge       = rem_sh >= {1'b0, den_r};
    rem_next = ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        shift <= num;
        den_r <= den;
        rem   <= '0;
        cnt   <= CNT_W'(NUM_W);
        busy  <= 1'b1;
      end else if (busy) begin
        shift <= {shift[NUM_W-2:0], ge};
        rem   <= rem_next;
        cnt   <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo = shift;

endmodule
`default_nettype wire

/* rtl/traction_torque_supervisor_unit.sv */
// frame and clear transactions are absorbed on accept, no result
// tick transactions: when torque is computed, the result comes from two bit-serial
// divisions, one after the other (slip ratio, then torque); only the slip division
// runs when torque is forced to zero (fault, braking, full derate)
// one transaction at a time; next accept the cycle after the result is registered
// synchronous active-high reset: config registers to defaults, all held data cleared
`default_nettype none
module traction_torque_supervisor_unit import tts_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         cmd,
  input  wire logic [10:0]        frame_id,
  input  wire logic [31:0]        time_ms,
  input  wire logic [3:0]         rolling_count,
  input  wire logic [9:0]         accel_pedal,
  input  wire logic [9:0]         brake_pedal,
  input  wire logic [15:0]        speed_front_left,
  input  wire logic [15:0]        speed_front_right,
  input  wire logic [15:0]        speed_rear_left,
  input  wire logic [15:0]        speed_rear_right,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [15:0]             torque_request,
  output logic [1:0]              drive_state,
  output logic signed [15:0]      slip_ratio,
  output logic                    counter_fault,
  output logic                    conflict_fault,
  output logic                    timeout_fault
);

  logic [10:0]        pedal_frame_id;
  logic [10:0]        wheel_frame_id;
  logic [9:0]         pedal_conflict_threshold;
  logic [15:0]        pedal_timeout;
  logic [15:0]        wheel_timeout;
  logic [15:0]        max_torque;
  logic signed [15:0] derate_start;
  logic signed [15:0] derate_cutoff;

  logic        pedal_seen;
  logic        count_seen;
  logic [3:0]  prior_count;
  logic [9:0]  held_accel;
  logic [9:0]  held_brake;
  logic [31:0] pedal_stamp;
  logic        wheels_seen;
  logic [15:0] held_speeds [4];
  logic [31:0] wheel_stamp;
  logic [2:0]  fault_flags;

  sup_state_t state, state_next;

  logic               slip_neg;
  logic signed [15:0] slip;
  logic [25:0]        base;
  logic [15:0]        left;
  logic [25:0]        tq_den;
  logic [41:0]        prod;
  logic [15:0]        torque;
  drive_state_t       dstate;

  logic             div_start;
  logic [NUM_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;
  logic             div_done;
  logic [NUM_W-1:0] div_quo;

  logic             wr;
  logic             in_fire;
  logic             pstale;
  logic             wstale;
  logic [16:0]      f_sum;
  logic [16:0]      r_sum;
  logic [16:0]      ref_den;
  logic [16:0]      mag;
  logic signed [15:0] slip_calc;
  logic signed [16:0] span;
  logic signed [16:0] left_calc;
  logic             faulted;
  logic             derating;
  logic             derate_live;

  assign pready   = 1'b1;
  assign wr       = psel && penable && pwrite;
  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    case (paddr[4:2])
      REG_PEDAL_ID:   prdata = {21'b0, pedal_frame_id};
      REG_WHEEL_ID:   prdata = {21'b0, wheel_frame_id};
      REG_THRESHOLD:  prdata = {22'b0, pedal_conflict_threshold};
      REG_PEDAL_TMO:  prdata = {16'b0, pedal_timeout};
      REG_WHEEL_TMO:  prdata = {16'b0, wheel_timeout};
      REG_MAX_TORQUE: prdata = {16'b0, max_torque};
      REG_DERATE_BEG: prdata = {{16{derate_start[15]}}, derate_start};
      REG_DERATE_CUT: prdata = {{16{derate_cutoff[15]}}, derate_cutoff};
      default:        prdata = '0;
    endcase
  end

  always_comb begin
    pstale = !pedal_seen ||
             ({1'b0, time_ms} > ({1'b0, pedal_stamp} + {17'b0, pedal_timeout}));
    wstale = !wheels_seen ||
             ({1'b0, time_ms} > ({1'b0, wheel_stamp} + {17'b0, wheel_timeout}));
    f_sum   = {1'b0, held_speeds[0]} + {1'b0, held_speeds[1]};
    r_sum   = {1'b0, held_speeds[2]} + {1'b0, held_speeds[3]};
    ref_den = (f_sum > REF_FLOOR_SUM) ? f_sum : REF_FLOOR_SUM;
    mag     = (r_sum < f_sum) ? (f_sum - r_sum) : (r_sum - f_sum);

    if (!wheels_seen) begin
      slip_calc = '0;
    end else if (slip_neg) begin
      slip_calc = (div_quo > NUM_W'(32768)) ? 16'sh8000 : -$signed(div_quo[15:0]);
    end else begin
      slip_calc = (div_quo > NUM_W'(32767)) ? 16'sh7fff : $signed(div_quo[15:0]);
    end

    span        = {derate_cutoff[15], derate_cutoff} - {derate_start[15], derate_start};
    left_calc   = {derate_cutoff[15], derate_cutoff} - {slip[15], slip};
    faulted     = (fault_flags != 3'b0) || !pedal_seen || !wheels_seen;
    derating    = slip > derate_start;
    derate_live = (span > 17'sd0) && (slip < derate_cutoff);
  end

  always_comb begin
    div_start = 1'b0;
    div_num   = (NUM_W'(mag) << SLIP_FRAC_BITS) + NUM_W'(ref_den >> 1);
    div_den   = DEN_W'(ref_den);
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_fire && cmd == CMD_TICK) state_next = S_SLIP;
      end
      S_SLIP: begin
        div_start  = 1'b1;
        state_next = S_SLIP_WAIT;
      end
      S_SLIP_WAIT: begin
        if (div_done) state_next = S_SLIP_SAT;
      end
      S_SLIP_SAT: state_next = S_DECIDE;
      S_DECIDE: begin
        if (faulted || held_brake > BRAKE_OVERRIDE) begin
          state_next = S_EMIT;
        end else if (derating && !derate_live) begin
          state_next = S_EMIT;
        end else begin
          state_next = S_MUL;
        end
      end
      S_MUL: state_next = S_TQ_START;
      S_TQ_START: begin
        div_start  = 1'b1;
        div_num    = NUM_W'(prod) + NUM_W'(tq_den >> 1);
        div_den    = DEN_W'(tq_den);
        state_next = S_TQ_WAIT;
      end
      S_TQ_WAIT: begin
        if (div_done) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid || out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  tts_serial_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pedal_frame_id           <= 11'd256;
      wheel_frame_id           <= 11'd257;
      pedal_conflict_threshold <= 10'd250;
      pedal_timeout            <= 16'd100;
      wheel_timeout            <= 16'd100;
      max_torque               <= 16'd2000;
      derate_start             <= 16'sd410;
      derate_cutoff            <= 16'sd819;
    end else if (wr) begin
      case (paddr[4:2])
        REG_PEDAL_ID:   pedal_frame_id           <= pwdata[10:0];
        REG_WHEEL_ID:   wheel_frame_id           <= pwdata[10:0];
        REG_THRESHOLD:  pedal_conflict_threshold <= pwdata[9:0];
        REG_PEDAL_TMO:  pedal_timeout            <= pwdata[15:0];
        REG_WHEEL_TMO:  wheel_timeout            <= pwdata[15:0];
        REG_MAX_TORQUE: max_torque               <= pwdata[15:0];
        REG_DERATE_BEG: derate_start             <= $signed(pwdata[15:0]);
        REG_DERATE_CUT: derate_cutoff            <= $signed(pwdata[15:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pedal_seen     <= 1'b0;
      count_seen     <= 1'b0;
      prior_count    <= '0;
      held_accel     <= '0;
      held_brake     <= '0;
      pedal_stamp    <= '0;
      wheels_seen    <= 1'b0;
      held_speeds[0] <= '0;
      held_speeds[1] <= '0;
      held_speeds[2] <= '0;
      held_speeds[3] <= '0;
      wheel_stamp    <= '0;
      fault_flags    <= '0;
    end else if (in_fire) begin
      case (cmd)
        CMD_FRAME: begin
          if (frame_id == pedal_frame_id) begin
            if (count_seen && rolling_count != (prior_count + 4'd1)) fault_flags[0] <= 1'b1;
            if (accel_pedal >= pedal_conflict_threshold &&
                brake_pedal >= pedal_conflict_threshold) fault_flags[1] <= 1'b1;
            prior_count <= rolling_count;
            count_seen  <= 1'b1;
            held_accel  <= accel_pedal;
            held_brake  <= brake_pedal;
            pedal_stamp <= time_ms;
            pedal_seen  <= 1'b1;
          end else if (frame_id == wheel_frame_id) begin
            held_speeds[0] <= speed_front_left;
            held_speeds[1] <= speed_front_right;
            held_speeds[2] <= speed_rear_left;
            held_speeds[3] <= speed_rear_right;
            wheel_stamp    <= time_ms;
            wheels_seen    <= 1'b1;
          end
        end
        CMD_TICK:  fault_flags[2] <= pstale || wstale;
        CMD_CLEAR: begin
          fault_flags <= '0;
          count_seen  <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_SLIP: begin
        slip_neg <= r_sum < f_sum;
        base     <= 26'(held_accel) * 26'(max_torque);
      end
      S_SLIP_SAT: slip <= slip_calc;
      S_DECIDE: begin
        torque <= '0;
        if (faulted) begin
          dstate <= DS_FAULT;
        end else if (held_brake > BRAKE_OVERRIDE) begin
          dstate <= DS_READY;
        end else if (derating) begin
          dstate <= DS_DERATE;
          left   <= left_calc[15:0];
          tq_den <= 26'(span[15:0]) * 26'(PEDAL_FULL);
        end else begin
          dstate <= DS_READY;
          left   <= 16'd1;
          tq_den <= 26'(PEDAL_FULL);
        end
      end
      S_MUL: prod <= 42'(base) * 42'(left);
      S_TQ_WAIT: begin
        if (div_done) torque <= (div_quo > NUM_W'(65535)) ? 16'hffff : div_quo[15:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_EMIT && (!out_valid || out_ready)) begin
      out_valid      <= 1'b1;
      torque_request <= torque;
      drive_state    <= dstate;
      slip_ratio     <= slip;
      counter_fault  <= fault_flags[0];
      conflict_fault <= fault_flags[1];
      timeout_fault  <= fault_flags[2];
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire
